// File: rtl/core/periodic_task_timer_table_top_macros.svh
// Assertion helpers shared by the timer table RTL.
// Both expect clk and rst_n in scope.
`ifndef PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ptt_pkg.sv
package ptt_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int RES_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_REGISTER = 3'd1;
    localparam logic [2:0] CMD_DELETE   = 3'd2;
    localparam logic [2:0] CMD_MODIFY   = 3'd3;
    localparam logic [2:0] CMD_EXECUTE  = 3'd4;

    localparam logic [1:0] KIND_ASSIGNED = 2'd0;
    localparam logic [1:0] KIND_FULL     = 2'd1;
    localparam logic [1:0] KIND_DUE      = 2'd2;
    localparam logic [1:0] KIND_DONE     = 2'd3;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    // write request into the slot store, one enable per lane
    typedef struct packed {
        logic        tag_we;
        logic        cd_we;
        logic        per_we;
        slot_idx_t   addr;
        logic [7:0]  tag;
        logic [15:0] cd;
        logic [15:0] period;
    } ptt_wr_t;

endpackage

// File: rtl/core/ptt_slot_ram.sv
module ptt_slot_ram
    import ptt_pkg::*;
(
    input  logic        clk,
    input  ptt_wr_t     wr,
    input  slot_idx_t   rd_addr,
    output logic [7:0]  rd_tag,
    output logic [15:0] rd_cd,
    output logic [15:0] rd_period
);

    logic [7:0]  tag_mem [SLOT_COUNT];
    logic [15:0] cd_mem  [SLOT_COUNT];
    logic [15:0] per_mem [SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.tag_we)
        begin
            tag_mem[wr.addr] <= wr.tag;
        end
        if (wr.cd_we)
        begin
            cd_mem[wr.addr] <= wr.cd;
        end
        if (wr.per_we)
        begin
            per_mem[wr.addr] <= wr.period;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_tag    <= tag_mem[rd_addr];
        rd_cd     <= cd_mem[rd_addr];
        rd_period <= per_mem[rd_addr];
    end

endmodule

// File: rtl/core/periodic_task_timer_table_top.sv
// Timer slot table with tick, register, delete, modify and execute commands.
// Request channel: command and its fields are taken at a rising edge with
// start high and busy low; busy stays high while a command is worked on.
// Result channel: result_strobe marks each result for exactly one cycle;
// last is set on the final result of a command. Results cannot be held off.
// Per command, one slot per cycle through the store's single read port:
//   delete, modify, unknown: result the cycle after the request, busy stays
//     low, so a new request may follow in the next cycle.
//   register: busy while it walks to the lowest free slot (full if none);
//     the result comes in the first cycle with busy low.
//   tick: busy while each slot is read, then written back if it is used.
//   execute: busy while slots are read; due results stream one per cycle
//     at most, the last one in the first cycle with busy low.
// Reset clears the used and due flags at once; slot contents are left as
// they are and their data is only used once a register has written them.
module periodic_task_timer_table_top
    import ptt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] start_delay,
    input  logic [15:0] reload_value,
    input  logic [3:0]  slot_index,
    input  logic [7:0]  handler_tag,
    output logic        result_strobe,
    output logic [1:0]  result_kind,
    output logic [3:0]  slot_number,
    output logic [7:0]  due_tag,
    output logic        last
);

    `include "periodic_task_timer_table_top_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;
    localparam logic [1:0] ST_REG  = 2'd2;
    localparam logic [1:0] ST_EXEC = 2'd3;

    localparam slot_idx_t LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [RES_W-1:0] LAST_RES = RES_W'(MAX_RESULTS - 1);

    logic [1:0]            state_reg, state_next;
    slot_idx_t             scan_reg, scan_next;
    logic                  iss_done_reg, iss_done_next;
    logic                  stg_valid_reg, stg_valid_next;
    slot_idx_t             stg_idx_reg, stg_idx_next;
    logic                  stg_last_reg, stg_last_next;
    logic [RES_W-1:0]      cnt_reg, cnt_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic [SLOT_COUNT-1:0] due_reg, due_next;
    logic [15:0]           delay_reg, delay_next;
    logic [15:0]           reload_reg, reload_next;
    logic [7:0]            tag_reg, tag_next;

    logic                  res_strobe_reg, res_strobe_next;
    logic [1:0]            res_kind_reg, res_kind_next;
    logic [3:0]            res_slot_reg, res_slot_next;
    logic [7:0]            res_tag_reg, res_tag_next;
    logic                  res_last_reg, res_last_next;

    ptt_wr_t               wr;
    logic [7:0]            rd_tag;
    logic [15:0]           rd_cd;
    logic [15:0]           rd_period;

    logic [SLOT_COUNT-1:0] pend;
    logic [SLOT_COUNT-1:0] pend_above;
    logic                  more_due;
    logic                  idx_ok;
    slot_idx_t             req_idx;
    logic [15:0]           cd_dec;
    logic                  accept;

    ptt_slot_ram u_ram
    (
        .clk       (clk),
        .wr        (wr),
        .rd_addr   (scan_reg),
        .rd_tag    (rd_tag),
        .rd_cd     (rd_cd),
        .rd_period (rd_period)
    );

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign idx_ok  = (32'(slot_index) < 32'(SLOT_COUNT));
    assign req_idx = SLOT_W'(slot_index);
    assign pend    = used_reg & due_reg;
    assign cd_dec  = (rd_cd != 16'd0) ? (rd_cd - 16'd1) : 16'd0;

    // due slots above the one in the stage decide whether this result is last
    always_comb
    begin
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            pend_above[j] = pend[j] && (j > int'(stg_idx_reg));
        end
    end
    assign more_due = |pend_above;

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        iss_done_next   = iss_done_reg;
        stg_valid_next  = 1'b0;
        stg_idx_next    = stg_idx_reg;
        stg_last_next   = stg_last_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        due_next        = due_reg;
        delay_next      = delay_reg;
        reload_next     = reload_reg;
        tag_next        = tag_reg;
        res_strobe_next = 1'b0;
        res_kind_next   = res_kind_reg;
        res_slot_next   = res_slot_reg;
        res_tag_next    = res_tag_reg;
        res_last_next   = res_last_reg;
        wr              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_next     = '0;
                    iss_done_next = 1'b0;
                    cnt_next      = '0;
                    delay_next    = start_delay;
                    reload_next   = reload_value;
                    tag_next      = handler_tag;
                    res_kind_next = KIND_DONE;
                    res_slot_next = 4'd0;
                    res_tag_next  = 8'd0;
                    res_last_next = 1'b1;
                    case (command)
                        CMD_TICK:     state_next = ST_TICK;
                        CMD_REGISTER: state_next = ST_REG;
                        CMD_EXECUTE:  state_next = ST_EXEC;
                        CMD_DELETE:
                        begin
                            if (idx_ok)
                            begin
                                used_next[req_idx] = 1'b0;
                                due_next[req_idx]  = 1'b0;
                            end
                            res_strobe_next = 1'b1;
                        end
                        CMD_MODIFY:
                        begin
                            wr.per_we       = idx_ok;
                            wr.addr         = req_idx;
                            wr.period       = reload_value;
                            res_strobe_next = 1'b1;
                        end
                        default:
                        begin
                            res_strobe_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_REG:
            begin
                if (!used_reg[scan_reg])
                begin
                    wr.tag_we           = 1'b1;
                    wr.cd_we            = 1'b1;
                    wr.per_we           = 1'b1;
                    wr.addr             = scan_reg;
                    wr.tag              = tag_reg;
                    wr.cd               = delay_reg;
                    wr.period           = reload_reg;
                    used_next[scan_reg] = 1'b1;
                    due_next[scan_reg]  = 1'b0;
                    res_strobe_next     = 1'b1;
                    res_kind_next       = KIND_ASSIGNED;
                    res_slot_next       = 4'(scan_reg);
                    state_next          = ST_IDLE;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    res_strobe_next = 1'b1;
                    res_kind_next   = KIND_FULL;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_TICK, ST_EXEC:
            begin
                // read side: one slot address per cycle
                if (!iss_done_reg)
                begin
                    stg_valid_next = 1'b1;
                    stg_idx_next   = scan_reg;
                    stg_last_next  = (scan_reg == LAST_SLOT);
                    if (scan_reg == LAST_SLOT)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + 1'b1;
                    end
                end

                // stage side: read data belongs to stg_idx_reg
                if (stg_valid_reg && state_reg == ST_TICK)
                begin
                    if (used_reg[stg_idx_reg])
                    begin
                        wr.cd_we = 1'b1;
                        wr.addr  = stg_idx_reg;
                        if (cd_dec == 16'd0)
                        begin
                            wr.cd                 = rd_period;
                            due_next[stg_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            wr.cd = cd_dec;
                        end
                    end
                    if (stg_last_reg)
                    begin
                        res_strobe_next = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (stg_valid_reg)
                begin
                    if (pend[stg_idx_reg])
                    begin
                        due_next[stg_idx_reg] = 1'b0;
                        if (rd_period == 16'd0)
                        begin
                            used_next[stg_idx_reg] = 1'b0;
                        end
                        res_strobe_next = 1'b1;
                        res_kind_next   = KIND_DUE;
                        res_slot_next   = 4'(stg_idx_reg);
                        res_tag_next    = rd_tag;
                        res_last_next   = !more_due || (cnt_reg == LAST_RES);
                        cnt_next        = cnt_reg + 1'b1;
                        if (!more_due || (cnt_reg == LAST_RES))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else if (stg_last_reg)
                    begin
                        // nothing was due
                        res_strobe_next = 1'b1;
                        res_kind_next   = KIND_DONE;
                        res_slot_next   = 4'd0;
                        res_tag_next    = 8'd0;
                        res_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_reg       <= '0;
            iss_done_reg   <= 1'b0;
            stg_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            used_reg       <= '0;
            due_reg        <= '0;
            res_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            iss_done_reg   <= iss_done_next;
            stg_valid_reg  <= stg_valid_next;
            cnt_reg        <= cnt_next;
            used_reg       <= used_next;
            due_reg        <= due_next;
            res_strobe_reg <= res_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_idx_reg  <= stg_idx_next;
        stg_last_reg <= stg_last_next;
        delay_reg    <= delay_next;
        reload_reg   <= reload_next;
        tag_reg      <= tag_next;
        res_kind_reg <= res_kind_next;
        res_slot_reg <= res_slot_next;
        res_tag_reg  <= res_tag_next;
        res_last_reg <= res_last_next;
    end

    assign result_strobe = res_strobe_reg;
    assign result_kind   = res_kind_reg;
    assign slot_number   = res_slot_reg;
    assign due_tag       = res_tag_reg;
    assign last          = res_last_reg;

    `PTT_ASSERT_IMP(a_more_keeps_busy, result_strobe && !last, busy, "non-final result while idle")
    `PTT_ASSERT_IMP(a_single_is_last, result_strobe && (result_kind != KIND_DUE), last, "single result not last")
    `PTT_ASSERT_NXT(a_delete_answers, accept && (command == CMD_DELETE), result_strobe && last, "delete gave no result")
    `PTT_ASSERT_IMP(a_assigned_used, result_strobe && (result_kind == KIND_ASSIGNED), used_reg[SLOT_W'(slot_number)], "assigned slot not in use")

endmodule
